// ===== hdl/wtp_pkg.sv =====
// Package for the three-voice wavetable song player.
// Holds table sizes, command and register codes, reset values and shared structs.
// No dependencies.
package wtp_pkg;

	localparam int SONG_DEPTH = 256;
	localparam int SONG_AW    = $clog2(SONG_DEPTH);
	localparam int SINE_DEPTH = 513;
	localparam int SINE_AW    = $clog2(SINE_DEPTH);

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 88;

	localparam logic [15:0] PHASE_LIMIT       = 16'h803f;
	localparam logic [15:0] NOTE_TICKS_RESET  = 16'h07a1;
	localparam logic [8:0]  SONG_LENGTH_RESET = 9'd256;
	localparam logic [31:0] TPS_RESET         = 32'h0000_f424;

	localparam logic [1:0] CMD_TICK      = 2'd0;
	localparam logic [1:0] CMD_LOAD_SINE = 2'd1;
	localparam logic [1:0] CMD_LOAD_SONG = 2'd2;

	localparam logic [1:0] CFG_NOTE_TICKS       = 2'd0;
	localparam logic [1:0] CFG_SONG_LENGTH      = 2'd1;
	localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd2;

	typedef logic [SINE_AW-1:0] sine_idx_t;

	typedef struct packed {
		logic [15:0] voice3_step;
		logic [15:0] voice2_step;
		logic [15:0] voice1_step;
	} song_entry_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [31:0] subseconds;
		logic [7:0]  song_position;
	} timing_t;

endpackage

// ===== hdl/three_voice_wavetable_song_player.sv =====
// Top level of the three-voice wavetable song player.
// Depends on wtp_pkg, wtp_ram, wtp_sequencer and wtp_phase.
//
// Usage:
//   The slave stream carries requests. s_tuser is the command: sample tick,
//   load sine entry or load song entry. Loads write the sine table (513
//   entries) or the song table (256 entries of three voice steps); loads at
//   addresses beyond a table are dropped. Loads give no result.
//   Every sample tick gives one result on the master stream: the mixed
//   sample, the seconds and subseconds clock and the song position.
//   The configuration port writes note_ticks, song_length and
//   ticks_per_second; write it only while no tick is in flight.
// Timing:
//   One request is accepted per cycle while no stall holds the pipeline. A
//   tick's result reaches m_tvalid in order through song table read at the
//   accepting edge, phase update with sine table read, then mix into the
//   output register; both table reads have registered data.
// Reset:
//   arst_n clears phases, note timer and index, the clock and the pipeline,
//   and loads the register defaults. Table contents are undefined until loaded.
// Stall:
//   When the output register holds a result and m_tready is low, the whole
//   pipeline holds and s_tready drops until the result is taken.
module three_voice_wavetable_song_player import wtp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata from bit 0: address[9:0], sine_value[15:0], voice1_step[15:0],
	// voice2_step[15:0], voice3_step[15:0], zero fill[5:0]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: command[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata from bit 0: mixed_sample[15:0], seconds[31:0], subseconds[31:0],
	// song_position[7:0]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	logic [9:0]  address;
	logic [15:0] sine_value;
	song_entry_t load_entry;

	logic advance;
	logic accept;
	logic tick_acc;
	logic sine_we;
	logic song_we;

	logic [7:0]  note_index;
	timing_t     timing_next;
	song_entry_t song_rdata;
	sine_idx_t   sine_idx [3];
	logic [15:0] sine_rdata [3];
	logic [15:0] mix;

	logic    valid_s1;
	timing_t timing_s1;
	logic    valid_s2;
	timing_t timing_s2;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// unpack the request
	assign address                = s_tdata[9:0];
	assign sine_value             = s_tdata[25:10];
	assign load_entry.voice1_step = s_tdata[41:26];
	assign load_entry.voice2_step = s_tdata[57:42];
	assign load_entry.voice3_step = s_tdata[73:58];

	// the pipeline moves as a whole unless a result waits in the output register
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && s_tready;
	assign tick_acc = accept && (s_tuser == CMD_TICK);
	assign sine_we  = accept && (s_tuser == CMD_LOAD_SINE) && (32'(address) < SINE_DEPTH);
	assign song_we  = accept && (s_tuser == CMD_LOAD_SONG) && (32'(address) < SONG_DEPTH);

	// stage 0: note and clock bookkeeping, song entry read at the current note
	wtp_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick        (tick_acc),
		.note_index  (note_index),
		.timing_next (timing_next)
	);

	wtp_ram #(
		.WIDTH ($bits(song_entry_t)),
		.DEPTH (SONG_DEPTH)
	) u_song_ram (
		.clk   (clk),
		.we    (song_we),
		.waddr (address[SONG_AW-1:0]),
		.wdata (load_entry),
		.re    (tick_acc),
		.raddr (note_index[SONG_AW-1:0]),
		.rdata (song_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= tick_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			timing_s1 <= timing_next;
		end
	end

	// stage 1: advance the phases and read one sine sample per voice
	wtp_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance && valid_s1),
		.steps    (song_rdata),
		.sine_idx (sine_idx)
	);

	// one copy of the sine table per voice, all written by every sine load
	for (genvar v = 0; v < 3; v++) begin : g_sine
		wtp_ram #(
			.WIDTH (16),
			.DEPTH (SINE_DEPTH)
		) u_sine_ram (
			.clk   (clk),
			.we    (sine_we),
			.waddr (address[SINE_AW-1:0]),
			.wdata (sine_value),
			.re    (advance),
			.raddr (sine_idx[v]),
			.rdata (sine_rdata[v])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			timing_s2 <= timing_s1;
		end
	end

	// stage 2: mix, each sample scaled by 64, wrapping at 16 bits
	assign mix = {sine_rdata[0][9:0], 6'b0} + {sine_rdata[1][9:0], 6'b0}
		+ {sine_rdata[2][9:0], 6'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			out_data_q <= {timing_s2.song_position, timing_s2.subseconds,
				timing_s2.seconds, mix};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> valid_s1)
		else $error("accepted tick missing from stage 1");

	a_load_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_tuser != CMD_TICK) |=> !valid_s1)
		else $error("load request produced a pipeline entry");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(valid_s1) && $stable(valid_s2))
		else $error("pipeline moved during a stall");

	a_reach_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && advance |=> m_tvalid)
		else $error("stage 2 result did not reach the output register");

endmodule

// ===== hdl/wtp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read returns the contents before a write in the same cycle. No dependencies.
module wtp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/wtp_sequencer.sv =====
// Note sequencer and seconds clock, plus the configuration registers.
// Depends on wtp_pkg.
module wtp_sequencer import wtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        tick,
	output logic [7:0]  note_index,
	output timing_t     timing_next
);

	logic [15:0] note_ticks_q;
	logic [8:0]  song_length_q;
	logic [31:0] tps_q;
	logic [15:0] note_timer_q;
	logic [7:0]  note_index_q;
	logic [31:0] seconds_q;
	logic [31:0] subseconds_q;

	logic [15:0] timer_d;
	logic [7:0]  index_d;
	logic [8:0]  index_inc;
	logic [31:0] sub_inc;
	logic [31:0] seconds_d;
	logic [31:0] sub_d;

	always_comb begin
		index_inc = {1'b0, note_index_q} + 9'd1;
		if (note_timer_q < note_ticks_q) begin
			timer_d = note_timer_q + 16'd1;
			index_d = note_index_q;
		end else begin
			timer_d = '0;
			if (index_inc >= song_length_q || 32'(index_inc) >= SONG_DEPTH
					|| index_inc > 9'd255) begin
				index_d = '0;
			end else begin
				index_d = index_inc[7:0];
			end
		end

		sub_inc = subseconds_q + 32'd1;
		if (sub_inc >= tps_q) begin
			sub_d     = '0;
			seconds_d = seconds_q + 32'd1;
		end else begin
			sub_d     = sub_inc;
			seconds_d = seconds_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_ticks_q  <= NOTE_TICKS_RESET;
			song_length_q <= SONG_LENGTH_RESET;
			tps_q         <= TPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NOTE_TICKS:       note_ticks_q  <= cfg_data[15:0];
				CFG_SONG_LENGTH:      song_length_q <= cfg_data[8:0];
				CFG_TICKS_PER_SECOND: tps_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_timer_q <= '0;
			note_index_q <= '0;
			seconds_q    <= '0;
			subseconds_q <= '0;
		end else if (tick) begin
			note_timer_q <= timer_d;
			note_index_q <= index_d;
			seconds_q    <= seconds_d;
			subseconds_q <= sub_d;
		end
	end

	assign note_index                = note_index_q;
	assign timing_next.seconds       = seconds_d;
	assign timing_next.subseconds    = sub_d;
	assign timing_next.song_position = index_d;

endmodule

// ===== hdl/wtp_phase.sv =====
// Three phase accumulators; each step adds the note increment minus one.
// Depends on wtp_pkg.
module wtp_phase import wtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  song_entry_t steps,
	output sine_idx_t   sine_idx [3]
);

	logic [15:0] phase_q [3];
	logic [15:0] phase_d [3];
	logic [15:0] step    [3];

	assign step[0] = steps.voice1_step;
	assign step[1] = steps.voice2_step;
	assign step[2] = steps.voice3_step;

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			phase_d[v] = phase_q[v] + step[v] - 16'd1;
			// clear once past the end of the sine table's span
			if (phase_d[v] > PHASE_LIMIT) begin
				phase_d[v] = '0;
			end
			sine_idx[v] = phase_d[v][15:6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < 3; v++) begin
				phase_q[v] <= '0;
			end
		end else if (en) begin
			for (int v = 0; v < 3; v++) begin
				phase_q[v] <= phase_d[v];
			end
		end
	end

endmodule

// ===== tb/three_voice_wavetable_song_player_tb.sv =====
// Self-checking testbench for the three-voice wavetable song player.
// Fills both tables, walks a directed request list, then runs random phases
// against a local predictor of the player. Depends on wtp_pkg and the player RTL.
`timescale 1ns / 100ps

module three_voice_wavetable_song_player_tb;
	import wtp_pkg::*;

	// Command code that the player leaves unused; it must drop such requests.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Cycles to let pass after the last result so that trailing loads retire.
	localparam int SETTLE_CYCLES  = 8;
	// One long output hold-off, long enough to back the pipeline up to s_tready.
	localparam int HOLD_CYCLES    = 400;
	// Cycles without any accept on either stream before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;

	// One request on the slave stream.
	typedef struct packed {
		logic [1:0]  cmd;
		song_entry_t steps;
		logic [15:0] sine;
		logic [9:0]  addr;
	} player_req_t;

	// One result, laid out exactly as m_tdata (mixed sample in the low bits).
	typedef struct packed {
		logic [7:0]  position;
		logic [31:0] subseconds;
		logic [31:0] seconds;
		logic [15:0] mixed;
	} player_out_t;

	// Directed list entry: either a request or a configuration change.
	typedef struct packed {
		bit          is_cfg;
		player_req_t req;
		bit          typed;
		player_out_t want;
		logic [15:0] nt;
		logic [8:0]  sl;
		logic [31:0] tps;
	} dir_row_t;

	// One random phase: register settings and the number of counted requests.
	typedef struct packed {
		logic [15:0] nt;
		logic [8:0]  sl;
		logic [31:0] tps;
		logic [15:0] items;
	} phase_plan_t;

	// Block inputs, all known from time zero.
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [1:0]            s_tuser   = CMD_TICK;
	logic                  m_tready  = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [1:0]            cfg_index = CFG_NOTE_TICKS;
	logic [31:0]           cfg_data  = '0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Predictor state: register copies, voice phases, song sequencer, clock.
	logic [15:0] note_ticks_cfg = NOTE_TICKS_RESET;
	logic [8:0]  song_len_cfg   = SONG_LENGTH_RESET;
	logic [31:0] tps_cfg        = TPS_RESET;
	logic [15:0] voice_phase [3] = '{16'd0, 16'd0, 16'd0};
	logic [15:0] note_timer     = '0;
	logic [7:0]  note_idx       = '0;
	logic [31:0] sec_cnt        = '0;
	logic [31:0] subsec_cnt     = '0;
	logic [15:0] sine_shadow [SINE_DEPTH];
	song_entry_t song_shadow [SONG_DEPTH];

	// Results still owed by the player, oldest first.
	player_out_t pending_samples [$];

	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned burst_left     = 0;
	int unsigned hold_asked     = 0;
	int unsigned hold_served    = 0;
	int unsigned hold_left      = 0;
	int unsigned rx_left        = 0;
	int unsigned rx_mode        = 0;
	logic [4:0]  rx_pat         = '0;
	player_out_t seen_out;
	player_out_t want_out;

	dir_row_t    dir_rows [$];
	phase_plan_t phase_plans [$];

	three_voice_wavetable_song_player u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted request to the local copy of the player. Loads update
	// the shadow tables; a tick steps the three voices, mixes their samples,
	// advances the song position and the seconds clock, and yields one result.
	function automatic void advance_player(input player_req_t r, output bit gives,
			output player_out_t res);
		logic [15:0] step [3];
		logic [15:0] p;
		logic [31:0] mix;
		logic [8:0]  nxt;
		gives = 1'b0;
		res = '0;
		case (r.cmd)
			CMD_LOAD_SINE: begin
				if (r.addr < SINE_DEPTH)
					sine_shadow[r.addr] = r.sine;
			end
			CMD_LOAD_SONG: begin
				if (r.addr < SONG_DEPTH)
					song_shadow[r.addr] = r.steps;
			end
			CMD_TICK: begin
				// Steps come from the note in effect before this tick's advance.
				step[0] = song_shadow[note_idx].voice1_step;
				step[1] = song_shadow[note_idx].voice2_step;
				step[2] = song_shadow[note_idx].voice3_step;
				mix = '0;
				for (int v = 0; v < 3; v++) begin
					p = voice_phase[v] + step[v] - 16'd1;
					if (p > PHASE_LIMIT)
						p = '0;
					voice_phase[v] = p;
					mix = mix + (32'(sine_shadow[p >> 6]) << 6);
				end
				if (note_timer < note_ticks_cfg) begin
					note_timer = note_timer + 16'd1;
				end else begin
					// Wrap at the song length or the table depth, whichever comes first.
					nxt = {1'b0, note_idx} + 9'd1;
					if (nxt >= song_len_cfg || nxt >= SONG_DEPTH)
						nxt = '0;
					note_idx = nxt[7:0];
					note_timer = '0;
				end
				subsec_cnt = subsec_cnt + 32'd1;
				if (subsec_cnt >= tps_cfg) begin
					sec_cnt = sec_cnt + 32'd1;
					subsec_cnt = '0;
				end
				res.mixed = mix[15:0];
				res.seconds = sec_cnt;
				res.subseconds = subsec_cnt;
				res.position = note_idx;
				gives = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Mix short and full-range steps so phases both sweep the table and wrap.
	function automatic song_entry_t random_steps();
		song_entry_t e;
		e.voice1_step = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(1, 512));
		e.voice2_step = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(1, 512));
		e.voice3_step = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(1, 512));
		return e;
	endfunction

	// Mostly ticks, with in-range loads, a few out-of-range loads and unused
	// commands; flag the ones the player should drop.
	function automatic player_req_t random_request(output bit ignored);
		player_req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r.addr = 10'($urandom);
		r.sine = 16'($urandom);
		r.steps = random_steps();
		ignored = 1'b0;
		if (pick < 70) begin
			r.cmd = CMD_TICK;
		end else if (pick < 80) begin
			r.cmd = CMD_LOAD_SINE;
			r.addr = 10'($urandom_range(0, SINE_DEPTH - 1));
		end else if (pick < 90) begin
			r.cmd = CMD_LOAD_SONG;
			r.addr = 10'($urandom_range(0, SONG_DEPTH - 1));
		end else if (pick < 93) begin
			r.cmd = CMD_LOAD_SINE;
			r.addr = 10'($urandom_range(SINE_DEPTH, 1023));
			ignored = 1'b1;
		end else if (pick < 96) begin
			r.cmd = CMD_LOAD_SONG;
			r.addr = 10'($urandom_range(SONG_DEPTH, 1023));
			ignored = 1'b1;
		end else begin
			r.cmd = CMD_UNUSED;
			ignored = 1'b1;
		end
		return r;
	endfunction

	function automatic dir_row_t req_row(input logic [1:0] cmd, input logic [9:0] addr,
			input logic [15:0] sine, input logic [15:0] v1, input logic [15:0] v2,
			input logic [15:0] v3);
		dir_row_t row;
		row = '0;
		row.req.cmd = cmd;
		row.req.addr = addr;
		row.req.sine = sine;
		row.req.steps = '{voice3_step: v3, voice2_step: v2, voice1_step: v1};
		return row;
	endfunction

	// A tick row; with typed set, the result below is what must come back.
	function automatic dir_row_t tick_row(input bit typed, input logic [15:0] mixed,
			input logic [31:0] sec, input logic [31:0] sub, input logic [7:0] pos);
		dir_row_t row;
		row = '0;
		row.req.cmd = CMD_TICK;
		row.typed = typed;
		row.want = '{position: pos, subseconds: sub, seconds: sec, mixed: mixed};
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [15:0] nt, input logic [8:0] sl,
			input logic [31:0] tps);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.nt = nt;
		row.sl = sl;
		row.tps = tps;
		return row;
	endfunction

	// Offer one request and hold it until accepted. The sender runs in bursts
	// of random length; a burst may open with a gap in which tvalid is low.
	// The handshake is sampled at the falling edge so that it is settled, and
	// the predictor runs right after the rising edge that takes the request.
	task automatic send_request(input player_req_t r, input bit typed,
			input player_out_t want);
		int unsigned gap;
		bit          taken;
		bit          gives;
		player_out_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {6'b0, r.steps, r.sine, r.addr};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		advance_player(r, gives, pred);
		if (gives)
			pending_samples.push_back(typed ? want : pred);
	endtask

	// Stop offering and wait until every owed result is out, then let any
	// trailing loads retire.
	task automatic drain_player();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Write all three registers on consecutive edges; call only when idle.
	task automatic set_config(input logic [15:0] nt, input logic [8:0] sl,
			input logic [31:0] tps);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NOTE_TICKS;
		cfg_data <= {16'b0, nt};
		@(posedge clk);
		cfg_index <= CFG_SONG_LENGTH;
		cfg_data <= {23'b0, sl};
		@(posedge clk);
		cfg_index <= CFG_TICKS_PER_SECOND;
		cfg_data <= tps;
		@(posedge clk);
		cfg_we <= 1'b0;
		note_ticks_cfg = nt;
		song_len_cfg = sl;
		tps_cfg = tps;
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Receiver: keep switching between randomly picked stall patterns (always ready, light
	// stalls, heavy stalls, fixed rhythm). A hold-off request from the main
	// sequence overrides the pattern and holds m_tready low for the hold-off.
	always @(posedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = 60;
		end
		rx_left--;
		rx_pat <= rx_pat + 5'd1;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_pat[2:0] != 3'd0) && (rx_pat[4:3] != 2'd3);
			endcase
		end
	end

	// Result checker: a handshake seen at the falling edge completes at the
	// next rising edge. Compare field by field with the oldest owed result.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_out = player_out_t'(m_tdata);
			if (pending_samples.size() == 0) begin
				flag_mismatch("unexpected result", longint'(seen_out), 0);
			end else begin
				want_out = pending_samples.pop_front();
				if (seen_out.mixed != want_out.mixed)
					flag_mismatch("mixed_sample", seen_out.mixed, want_out.mixed);
				if (seen_out.seconds != want_out.seconds)
					flag_mismatch("seconds", seen_out.seconds, want_out.seconds);
				if (seen_out.subseconds != want_out.subseconds)
					flag_mismatch("subseconds", seen_out.subseconds, want_out.subseconds);
				if (seen_out.position != want_out.position)
					flag_mismatch("song_position", seen_out.position, want_out.position);
			end
		end
	end

	// Watchdog: end the run when neither stream moves for too long.
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		player_req_t r;
		bit          ignored;
		int unsigned counted;

		// Directed list. Sine entry 0 and song entry 0 are set so that every
		// phase stays at 0 and the mix reads straight off sine entry 0: a step
		// of 1 keeps the phase, and steps of 0 or all ones wrap past the limit
		// and clear it. Some dropped requests in the middle target song entry 0
		// and would disturb it if taken.
		dir_rows.push_back(req_row(CMD_LOAD_SINE, 10'd0, 16'h0001, 16'h0, 16'h0, 16'h0));
		dir_rows.push_back(req_row(CMD_LOAD_SONG, 10'd0, 16'h0, 16'h0001, 16'h0001, 16'h0001));
		dir_rows.push_back(tick_row(1'b1, 16'h00c0, 32'd0, 32'd1, 8'd0));
		dir_rows.push_back(req_row(CMD_LOAD_SINE, 10'd0, 16'hffff, 16'h0, 16'h0, 16'h0));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd0, 32'd2, 8'd0));
		dir_rows.push_back(req_row(CMD_LOAD_SONG, 10'd0, 16'h0, 16'h0000, 16'h0000, 16'h0000));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd0, 32'd3, 8'd0));
		dir_rows.push_back(req_row(CMD_LOAD_SONG, 10'd0, 16'h0, 16'hffff, 16'hffff, 16'hffff));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd0, 32'd4, 8'd0));
		// Loads beyond either table and the unused command must be dropped.
		dir_rows.push_back(req_row(CMD_LOAD_SINE, 10'd513, 16'h0000, 16'h0, 16'h0, 16'h0));
		dir_rows.push_back(req_row(CMD_LOAD_SINE, 10'h3ff, 16'h1234, 16'h0, 16'h0, 16'h0));
		dir_rows.push_back(req_row(CMD_LOAD_SONG, 10'd256, 16'h0, 16'h0101, 16'h0101, 16'h0101));
		dir_rows.push_back(req_row(CMD_LOAD_SONG, 10'h3ff, 16'h0, 16'h0101, 16'h0101, 16'h0101));
		dir_rows.push_back(req_row(CMD_UNUSED, 10'd0, 16'h0000, 16'h0101, 16'h0101, 16'h0101));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd0, 32'd5, 8'd0));
		// Zero song length holds the index; zero ticks per second bumps seconds
		// every tick.
		dir_rows.push_back(cfg_row(16'd0, 9'd0, 32'd0));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd1, 32'd0, 8'd0));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd2, 32'd0, 8'd0));
		dir_rows.push_back(cfg_row(16'd0, 9'd1, 32'd0));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd3, 32'd0, 8'd0));
		// One-tick notes: the position moves on every tick.
		dir_rows.push_back(cfg_row(16'd0, 9'd256, 32'hffff_ffff));
		dir_rows.push_back(tick_row(1'b1, 16'hff40, 32'd3, 32'd1, 8'd1));
		dir_rows.push_back(tick_row(1'b0, '0, '0, '0, '0));
		dir_rows.push_back(cfg_row(16'hffff, 9'd256, 32'd1));
		dir_rows.push_back(tick_row(1'b0, '0, '0, '0, '0));
		dir_rows.push_back(tick_row(1'b0, '0, '0, '0, '0));

		// Random phases: extremes of each register, out-of-range song lengths,
		// and a return to the reset values at the end.
		phase_plans.push_back('{nt: 16'd3, sl: 9'd256, tps: 32'd5, items: 16'd20});
		phase_plans.push_back('{nt: 16'd0, sl: 9'd300, tps: 32'd7, items: 16'd360});
		phase_plans.push_back('{nt: 16'd1, sl: 9'd5, tps: 32'd1, items: 16'd20});
		phase_plans.push_back('{nt: 16'hffff, sl: 9'd17, tps: 32'hffff_ffff, items: 16'd60});
		phase_plans.push_back('{nt: 16'd0, sl: 9'd1, tps: 32'd0, items: 16'd15});
		phase_plans.push_back('{nt: 16'd2, sl: 9'd0, tps: 32'd3, items: 16'd15});
		phase_plans.push_back('{nt: 16'd0, sl: 9'd511, tps: 32'd100, items: 16'd40});
		phase_plans.push_back('{nt: 16'($urandom_range(0, 7)), sl: 9'($urandom_range(1, 256)),
			tps: 32'($urandom_range(1, 50)), items: 16'd20});
		phase_plans.push_back('{nt: NOTE_TICKS_RESET, sl: SONG_LENGTH_RESET, tps: TPS_RESET,
			items: 16'd20});

		// Hold reset once, at the start of the run.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both tables completely so that no tick ever reads an entry
		// that was never written.
		for (int i = 0; i < SINE_DEPTH; i++) begin
			r = '0;
			r.cmd = CMD_LOAD_SINE;
			r.addr = 10'(i);
			r.sine = 16'($urandom);
			send_request(r, 1'b0, '0);
		end
		for (int i = 0; i < SONG_DEPTH; i++) begin
			r = '0;
			r.cmd = CMD_LOAD_SONG;
			r.addr = 10'(i);
			r.steps = random_steps();
			send_request(r, 1'b0, '0);
		end

		// Walk the directed list; register changes wait for an idle player.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain_player();
				set_config(dir_rows[i].nt, dir_rows[i].sl, dir_rows[i].tps);
			end else begin
				send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		foreach (phase_plans[p]) begin
			drain_player();
			set_config(phase_plans[p].nt, phase_plans[p].sl, phase_plans[p].tps);
			// Hold the output off early in this phase while requests keep
			// coming, so the pipeline fills and s_tready drops.
			if (p == 1)
				hold_asked++;
			counted = 0;
			while (counted < phase_plans[p].items) begin
				// Pause mid-phase until every owed result is out.
				if (p == 3 && counted == 50)
					drain_player();
				r = random_request(ignored);
				send_request(r, 1'b0, '0);
				if (!ignored)
					counted++;
			end
		end

		drain_player();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/wtp_pkg.sv
hdl/wtp_ram.sv
hdl/wtp_sequencer.sv
hdl/wtp_phase.sv
hdl/three_voice_wavetable_song_player.sv
tb/three_voice_wavetable_song_player_tb.sv
